// File: sv/mtcs_pkg.sv
// Shared types and constants of the multithreaded core switch.
// Depends on nothing; imported by mtcs_exec, multithread_core_switch and the testbench.
package mtcs_pkg;

  localparam int THREADS         = 4;
  localparam int REGS_PER_THREAD = 8;

  localparam int DataW   = 32;
  localparam int PcW     = 16;
  localparam int RegW    = 3;
  localparam int ThrW    = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int ThrCntW = $clog2(THREADS + 1);
  localparam int RfDepth = THREADS * REGS_PER_THREAD;
  localparam int RfAw    = $clog2(RfDepth);

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SWITCH_MODE  = 1'b0,
    CFG_THREAD_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_ADDI = 3'd3,
    OP_SUBI = 3'd4,
    OP_LOAD = 3'd5,
    OP_STORE = 3'd6,
    OP_HALT = 3'd7
  } opcode_e;

  typedef enum logic {
    FUNC_INSN  = 1'b0,
    FUNC_LDATA = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_e;

  typedef struct packed {
    logic               func;
    logic [2:0]         opcode;
    logic [2:0]         dst_reg;
    logic [2:0]         src_reg;
    logic signed [31:0] src2_or_imm;
    logic signed [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic               fetch_valid;
    logic [2:0]         fetch_thread;
    logic [15:0]        fetch_pc;
    mem_op_e            mem_op;
    logic [31:0]        mem_addr;
    logic signed [31:0] mem_wdata;
    logic               all_done;
  } out_item_t;

  // Core architectural state except the register file.
  typedef struct packed {
    logic [ThrW-1:0]               cur;
    logic                          pend;
    logic [RegW-1:0]               tgt;
    logic [THREADS-1:0]            halted;
    logic [THREADS-1:0][PcW-1:0]   pc;
  } core_state_t;

  // Register file write request.
  typedef struct packed {
    logic             we;
    logic [ThrW-1:0]  thr;
    logic [RegW-1:0]  idx;
    logic [DataW-1:0] data;
  } rf_wr_t;

endpackage

// File: sv/multithread_core_switch.sv
// Top level of the multithreaded core switch: handshakes, register file, state.
// Depends on mtcs_pkg and mtcs_exec.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_item_i): one transfer is either
//    the fetched instruction of the current thread or the data of its load.
//  - Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//    result transfer per input transfer, in order: next fetch, memory request
//    and the all-done flag.
//  - Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): switch mode and thread
//    count, written while the core has nothing in flight.
// Result path: the item and its operands are registered at input transfer, then
//  executed into the output register once that register is free.
// Throughput: one item per cycle while the output is not stalled. The register file
//  read is registered at input transfer; the previous item's result is forwarded.
// Reset: all threads at PC 0, none halted, thread 0 current, no load pending,
//  registers read as zero (per-entry valid bits), blocked mode, one thread.
// Stall: while out_stall_i holds a result, the execute stage keeps its item and
//  in_stall_o rises only if that stage is also full.
module multithread_core_switch (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mtcs_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mtcs_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [mtcs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mtcs_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import mtcs_pkg::*;

  // config
  logic                fine_mode_q;
  logic [CfgDataW-1:0] tcnt_q;
  logic [ThrCntW-1:0]  n_used;

  // pipeline control
  logic e_vld_q, out_vld_q;
  logic out_free, e_fire, in_fire;

  // payload
  in_item_t  e_item_q;
  out_item_t out_q;

  // architectural state
  core_state_t state_q, state_d;
  rf_wr_t      wr;
  out_item_t   res;

  // register file: memory plus reset valid bits
  logic [DataW-1:0]   rf [RfDepth];
  logic [RfDepth-1:0] rf_vld_q;
  logic [ThrW-1:0]    rd_thr;
  logic [RfAw-1:0]    raddr_a, raddr_b, waddr;
  logic [ThrW+RegW-1:0] raddr_a_full, raddr_b_full, waddr_full;
  logic [DataW-1:0]   rd_a_q, rd_b_q, fwd_data_q;
  logic               vld_a_q, vld_b_q, fwd_a_q, fwd_b_q;
  logic [DataW-1:0]   op_a, op_b;

  // effective thread count: 0 acts as 1, saturates at THREADS
  always_comb begin
    priority if (tcnt_q == '0) begin
      n_used = ThrCntW'(1);
    end else if (tcnt_q > CfgDataW'(THREADS)) begin
      n_used = ThrCntW'(THREADS);
    end else begin
      n_used = tcnt_q[ThrCntW-1:0];
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign e_fire     = e_vld_q && out_free;
  assign in_stall_o = e_vld_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // operand read uses the thread that will be current when this item executes
  assign rd_thr       = e_fire ? state_d.cur : state_q.cur;
  assign raddr_a_full = {rd_thr, in_item_i.src_reg};
  assign raddr_b_full = {rd_thr, in_item_i.src2_or_imm[RegW-1:0]};
  assign waddr_full   = {wr.thr, wr.idx};
  assign raddr_a      = raddr_a_full[RfAw-1:0];
  assign raddr_b      = raddr_b_full[RfAw-1:0];
  assign waddr        = waddr_full[RfAw-1:0];

  assign op_a = fwd_a_q ? fwd_data_q : (vld_a_q ? rd_a_q : '0);
  assign op_b = fwd_b_q ? fwd_data_q : (vld_b_q ? rd_b_q : '0);

  mtcs_exec u_exec (
    .item_i      (e_item_q),
    .op_a_i      (op_a),
    .op_b_i      (op_b),
    .state_i     (state_q),
    .fine_mode_i (fine_mode_q),
    .n_used_i    (n_used),
    .state_o     (state_d),
    .wr_o        (wr),
    .res_o       (res)
  );

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      state_q     <= '0;
      rf_vld_q    <= '0;
      fine_mode_q <= 1'b0;
      tcnt_q      <= CfgDataW'(1);
    end else begin
      if (in_fire) begin
        e_vld_q <= 1'b1;
      end else if (e_fire) begin
        e_vld_q <= 1'b0;
      end
      if (e_fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (e_fire) begin
        state_q <= state_d;
        if (wr.we) begin
          rf_vld_q[waddr] <= 1'b1;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SWITCH_MODE:  fine_mode_q <= cfg_wdata_i[0];
          CFG_THREAD_COUNT: tcnt_q      <= cfg_wdata_i;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_item_q <= in_item_i;
    end
    if (e_fire) begin
      out_q <= res;
    end
  end

  // register file memory with registered reads and write-to-read forwarding
  always_ff @(posedge clk_i) begin
    if (e_fire && wr.we) begin
      rf[waddr] <= wr.data;
    end
    if (in_fire) begin
      rd_a_q     <= rf[raddr_a];
      rd_b_q     <= rf[raddr_b];
      vld_a_q    <= rf_vld_q[raddr_a];
      vld_b_q    <= rf_vld_q[raddr_b];
      fwd_a_q    <= e_fire && wr.we && (waddr == raddr_a);
      fwd_b_q    <= e_fire && wr.we && (waddr == raddr_b);
      fwd_data_q <= wr.data;
    end
  end

endmodule

// File: sv/mtcs_exec.sv
// Execute step of the multithreaded core: one item, state update, next fetch.
// Depends on mtcs_pkg.
module mtcs_exec (
  input  mtcs_pkg::in_item_t                 item_i,
  input  logic [mtcs_pkg::DataW-1:0]         op_a_i,
  input  logic [mtcs_pkg::DataW-1:0]         op_b_i,
  input  mtcs_pkg::core_state_t              state_i,
  input  logic                               fine_mode_i,
  input  logic [mtcs_pkg::ThrCntW-1:0]       n_used_i,
  output mtcs_pkg::core_state_t              state_o,
  output mtcs_pkg::rf_wr_t                   wr_o,
  output mtcs_pkg::out_item_t                res_o
);
  import mtcs_pkg::*;

  logic [DataW-1:0]   imm;
  logic [ThrCntW-1:0] cur_ext;
  logic [ThrCntW-1:0] start;
  logic [ThrCntW-1:0] s;
  logic [ThrCntW:0]   t;
  logic [ThrW-1:0]    sel;
  logic               found;
  logic               do_pick;
  logic               go_on;
  logic               all_halted;
  logic [THREADS-1:0] used_mask;

  assign imm     = item_i.src2_or_imm;
  assign cur_ext = ThrCntW'(state_i.cur);

  always_comb begin
    for (int i = 0; i < THREADS; i++) begin
      used_mask[i] = (ThrCntW'(i) < n_used_i);
    end
    all_halted = &(state_i.halted | ~used_mask);
  end

  always_comb begin
    state_o = state_i;
    wr_o    = '0;
    res_o   = '0;
    do_pick = 1'b0;
    start   = cur_ext;
    go_on   = fine_mode_i;
    s       = '0;
    t       = '0;
    sel     = '0;
    found   = 1'b0;

    wr_o.thr = state_i.cur;
    wr_o.idx = item_i.dst_reg;

    if (item_i.func == FUNC_LDATA) begin
      do_pick = 1'b1;
      if (state_i.pend) begin
        wr_o.we      = 1'b1;
        wr_o.idx     = state_i.tgt;
        wr_o.data    = item_i.load_data;
        state_o.pend = 1'b0;
        start        = cur_ext + ThrCntW'(1);
      end
    end else if (state_i.pend) begin
      res_o.all_done = all_halted;
    end else if (cur_ext >= n_used_i || state_i.halted[state_i.cur]) begin
      do_pick = 1'b1;
    end else begin
      if (opcode_e'(item_i.opcode) != OP_HALT) begin
        state_o.pc[state_i.cur] = state_i.pc[state_i.cur] + PcW'(1);
      end
      do_pick = 1'b1;
      unique case (opcode_e'(item_i.opcode))
        OP_NOP: ;
        OP_ADD: begin
          wr_o.we   = 1'b1;
          wr_o.data = op_a_i + op_b_i;
        end
        OP_SUB: begin
          wr_o.we   = 1'b1;
          wr_o.data = op_a_i - op_b_i;
        end
        OP_ADDI: begin
          wr_o.we   = 1'b1;
          wr_o.data = op_a_i + imm;
        end
        OP_SUBI: begin
          wr_o.we   = 1'b1;
          wr_o.data = op_a_i - imm;
        end
        OP_LOAD: begin
          // thread parks until its data returns; no fetch this time
          state_o.pend   = 1'b1;
          state_o.tgt    = item_i.dst_reg;
          res_o.mem_op   = MEM_READ;
          res_o.mem_addr = op_a_i + imm;
          res_o.all_done = all_halted;
          do_pick        = 1'b0;
        end
        OP_STORE: begin
          res_o.mem_op    = MEM_WRITE;
          res_o.mem_addr  = DataW'(item_i.dst_reg);
          res_o.mem_wdata = op_a_i + imm;
          go_on           = 1'b1;
        end
        OP_HALT: begin
          state_o.halted[state_i.cur] = 1'b1;
          go_on                       = 1'b1;
        end
      endcase
      start = go_on ? cur_ext + ThrCntW'(1) : cur_ext;
    end

    // round-robin search over threads in use, halted ones skipped
    if (do_pick) begin
      s = (start >= n_used_i) ? '0 : start;
      for (int k = 0; k < THREADS; k++) begin
        t = {1'b0, s} + (ThrCntW+1)'(k);
        if (t >= {1'b0, n_used_i}) begin
          t = t - {1'b0, n_used_i};
        end
        if (!found && (ThrCntW'(k) < n_used_i) && !state_o.halted[t[ThrW-1:0]]) begin
          found = 1'b1;
          sel   = t[ThrW-1:0];
        end
      end
      if (found) begin
        state_o.cur        = sel;
        res_o.fetch_valid  = 1'b1;
        res_o.fetch_thread = 3'(sel);
        res_o.fetch_pc     = state_o.pc[sel];
      end else begin
        state_o.cur    = s[ThrW-1:0];
        res_o.all_done = 1'b1;
      end
    end
  end

endmodule

// File: tb/multithread_core_switch_test.sv
// Self-checking testbench for multithread_core_switch: directed and random instruction streams.
// Depends on mtcs_pkg and the multithread_core_switch RTL; the core's behavior is
// predicted in-line and every result transfer is compared field by field.
`timescale 1ns / 1ps

module multithread_core_switch_test;
  import mtcs_pkg::*;

  // Clock and DUT ports. Every input starts at a known value.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  multithread_core_switch DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Core shadow state: register file, PCs, halted marks, current thread, the
  // outstanding load and the two config registers.
  // ---------------------------------------------------------------------------
  logic [31:0]        shadow_rf [THREADS][REGS_PER_THREAD];
  logic [15:0]        shadow_pc [THREADS];
  logic [THREADS-1:0] shadow_halted;
  int unsigned        shadow_cur;
  bit                 shadow_pend;
  logic [2:0]         shadow_tgt;
  bit                 shadow_mode;
  logic [3:0]         shadow_count;

  out_item_t expected_results [$];  // predicted transfers, oldest first
  int        executed_cnt;          // transfers that did real work (not ignored)
  int        mismatch_cnt;
  int        burst_left;            // sender: transfers left in current burst
  int        stall_style;           // receiver: current stall pattern
  int        stall_left;            // receiver: cycles left in that pattern

  task automatic clear_shadow();
    for (int t = 0; t < THREADS; t++) begin
      shadow_pc[t] = '0;
      for (int r = 0; r < REGS_PER_THREAD; r++) shadow_rf[t][r] = '0;
    end
    shadow_halted = '0;
    shadow_cur    = 0;
    shadow_pend   = 1'b0;
    shadow_tgt    = '0;
    shadow_mode   = 1'b0;
    shadow_count  = 4'd1;
  endtask

  // Effective thread count: 0 behaves as 1, anything above THREADS saturates.
  function automatic int unsigned threads_in_use();
    if (shadow_count == 0) return 1;
    if (shadow_count > THREADS) return THREADS;
    return 32'(shadow_count);
  endfunction

  function automatic bit every_thread_halted(int unsigned n);
    for (int unsigned t = 0; t < n; t++)
      if (!shadow_halted[t]) return 1'b0;
    return 1'b1;
  endfunction

  // Round-robin search for the next live thread, starting at 'start'. Updates
  // the current thread and fills the fetch / all_done fields of the result.
  task automatic select_next_thread(input int unsigned start, inout out_item_t res);
    int unsigned n;
    int unsigned t;
    n = threads_in_use();
    if (start >= n) start = 0;
    for (int unsigned k = 0; k < n; k++) begin
      t = (start + k) % n;
      if (!shadow_halted[t]) begin
        shadow_cur       = t;
        res.fetch_valid  = 1'b1;
        res.fetch_thread = 3'(t);
        res.fetch_pc     = shadow_pc[t];
        res.all_done     = 1'b0;
        return;
      end
    end
    // nobody left to run
    shadow_cur       = start;
    res.fetch_valid  = 1'b0;
    res.fetch_thread = '0;
    res.fetch_pc     = '0;
    res.all_done     = 1'b1;
  endtask

  // Executes one accepted transfer on the shadow state and returns the result
  // the core must produce for it.
  task automatic execute_transfer(input in_item_t item, output out_item_t res);
    int unsigned n;
    int unsigned cur;
    logic [31:0] a;
    logic [31:0] imm;
    bit          go_on;
    n   = threads_in_use();
    cur = shadow_cur;
    imm = item.src2_or_imm;
    res = '0;

    if (item.func == FUNC_LDATA) begin
      // Load data with no load outstanding only reports the current fetch.
      if (!shadow_pend) begin
        select_next_thread(cur, res);
        return;
      end
      shadow_rf[cur][shadow_tgt] = item.load_data;
      shadow_pend = 1'b0;
      executed_cnt++;
      select_next_thread(cur + 1, res);  // a returned load starts the search at the next thread
      return;
    end

    // Instruction while a load is outstanding: dropped, no fetch.
    if (shadow_pend) begin
      res.all_done = every_thread_halted(n);
      return;
    end
    // Current thread halted or no longer in use: dropped.
    if (cur >= n || shadow_halted[cur]) begin
      select_next_thread(cur, res);
      return;
    end

    executed_cnt++;
    a     = shadow_rf[cur][item.src_reg];
    go_on = shadow_mode;
    if (opcode_e'(item.opcode) != OP_HALT) shadow_pc[cur] = shadow_pc[cur] + 16'd1;

    case (opcode_e'(item.opcode))
      OP_ADD:  shadow_rf[cur][item.dst_reg] = a + shadow_rf[cur][imm[2:0]];
      OP_SUB:  shadow_rf[cur][item.dst_reg] = a - shadow_rf[cur][imm[2:0]];
      OP_ADDI: shadow_rf[cur][item.dst_reg] = a + imm;
      OP_SUBI: shadow_rf[cur][item.dst_reg] = a - imm;
      OP_LOAD: begin
        shadow_pend  = 1'b1;
        shadow_tgt   = item.dst_reg;
        res.mem_op   = MEM_READ;
        res.mem_addr = a + imm;
        res.all_done = every_thread_halted(n);
        return;  // no fetch until the data comes back
      end
      OP_STORE: begin
        // address is the dst field itself, data is reg[src] + imm
        res.mem_op    = MEM_WRITE;
        res.mem_addr  = {29'd0, item.dst_reg};
        res.mem_wdata = a + imm;
        go_on         = 1'b1;
      end
      OP_HALT: begin
        shadow_halted[cur] = 1'b1;
        go_on              = 1'b1;
      end
      default: ;
    endcase

    select_next_thread(go_on ? cur + 1 : cur, res);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    check_field("fetch_valid",  32'(got.fetch_valid),  32'(want.fetch_valid));
    check_field("fetch_thread", 32'(got.fetch_thread), 32'(want.fetch_thread));
    check_field("fetch_pc",     32'(got.fetch_pc),     32'(want.fetch_pc));
    check_field("mem_op",       32'(got.mem_op),       32'(want.mem_op));
    check_field("mem_addr",     got.mem_addr,          want.mem_addr);
    check_field("mem_wdata",    got.mem_wdata,         want.mem_wdata);
    check_field("all_done",     32'(got.all_done),     32'(want.all_done));
  endtask

  // Result monitor: one comparison per output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) report_mismatch("result transfer with nothing expected");
      else compare_result(out_item_o, expected_results.pop_front());
    end
  end

  // Receiver back-pressure: switches at random between free-running, light,
  // heavy and periodic stall patterns.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(32, 200);
    end
    stall_left--;
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((stall_left % 12) < 4);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transfer. The sender runs in bursts; between bursts it may drop
  // valid for a random gap. Prediction happens at the accepting edge so the
  // next item can be chosen from up-to-date shadow state.
  task automatic send_item(input in_item_t item);
    int        gap;
    out_item_t predicted;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_item_i  = item;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    execute_transfer(item, predicted);
    expected_results.push_back(predicted);
  endtask

  // Sender pause: hold off until every predicted result has been seen.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Config write; only called with the core drained.
  task automatic write_reg(input cfg_idx_e idx, input logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_SWITCH_MODE: shadow_mode  = val[0];
      default:         shadow_count = val;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mode write with junk in the upper bits; only bit 0 counts.
  task automatic write_mode(input bit fine_grained);
    logic [3:0] v;
    v    = 4'($urandom_range(0, 15));
    v[0] = fine_grained;
    write_reg(CFG_SWITCH_MODE, v);
  endtask

  function automatic in_item_t make_item(input func_e f, input opcode_e op,
                                         input logic [2:0] dst, input logic [2:0] src,
                                         input logic [31:0] imm, input logic [31:0] ldata);
    in_item_t it;
    it.func        = f;
    it.opcode      = op;
    it.dst_reg     = dst;
    it.src_reg     = src;
    it.src2_or_imm = imm;
    it.load_data   = ldata;
    return it;
  endfunction

  function automatic logic [31:0] random_imm();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic: load data follows a LOAD, instructions
  // otherwise; a small share of each is out of place. HALT is only issued on
  // the last thread so the rest stay alive for later phases.
  function automatic in_item_t random_item();
    in_item_t it;
    opcode_e  op;
    op = opcode_e'($urandom_range(0, 6));
    if (shadow_cur == THREADS - 1 && $urandom_range(0, 39) == 0) op = OP_HALT;
    it = make_item(FUNC_INSN, op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   random_imm(), $urandom);
    if (shadow_pend ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0))
      it.func = FUNC_LDATA;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config (blocked, one thread): arithmetic wrap, register index wrap
  // for ADD/SUB, load/store, and out-of-place load data / instructions.
  task automatic test_single_thread_ops();
    send_item(make_item(FUNC_INSN, OP_NOP,   3'd0, 3'd0, 32'h0,         32'h0));
    send_item(make_item(FUNC_INSN, OP_ADDI,  3'd1, 3'd0, 32'h7fff_ffff, 32'h0));
    send_item(make_item(FUNC_INSN, OP_ADDI,  3'd2, 3'd1, 32'h1,         32'h0));
    send_item(make_item(FUNC_INSN, OP_SUBI,  3'd3, 3'd0, 32'h8000_0000, 32'h0));
    send_item(make_item(FUNC_INSN, OP_ADD,   3'd4, 3'd1, 32'hffff_fffa, 32'h0));
    send_item(make_item(FUNC_INSN, OP_SUB,   3'd5, 3'd0, 32'h9,         32'h0));
    send_item(make_item(FUNC_INSN, OP_SUBI,  3'd6, 3'd2, 32'hffff_ffff, 32'h0));
    send_item(make_item(FUNC_INSN, OP_LOAD,  3'd7, 3'd1, 32'h8000_0001, 32'h0));
    // instruction while the load is outstanding is dropped
    send_item(make_item(FUNC_INSN, OP_ADDI,  3'd7, 3'd7, 32'h5,         32'h0));
    send_item(make_item(FUNC_LDATA, OP_NOP,  3'd0, 3'd0, 32'h0,         32'h8000_0000));
    // data with no load outstanding is dropped too
    send_item(make_item(FUNC_LDATA, OP_NOP,  3'd0, 3'd0, 32'h0,         32'h7fff_ffff));
    send_item(make_item(FUNC_INSN, OP_STORE, 3'd7, 3'd7, 32'hffff_ffff, 32'h0));
    send_item(make_item(FUNC_INSN, OP_ADD,   3'd0, 3'd7, 32'h7,         32'h0));
  endtask

  // Thread switching in both modes, plus thread counts that shrink under the
  // current thread, saturate above THREADS, and zero.
  task automatic test_thread_switching();
    wait_drained();
    write_mode(1'b1);
    write_reg(CFG_THREAD_COUNT, 4'd4);
    repeat (3) send_item(make_item(FUNC_INSN, OP_NOP, 3'd0, 3'd0, 32'h0, 32'h0));
    // current thread is now past the new count: instruction dropped
    wait_drained();
    write_reg(CFG_THREAD_COUNT, 4'd2);
    send_item(make_item(FUNC_INSN, OP_ADDI, 3'd1, 3'd1, 32'h3, 32'h0));
    wait_drained();
    write_reg(CFG_THREAD_COUNT, 4'd15);
    write_mode(1'b0);
    send_item(make_item(FUNC_INSN, OP_STORE, 3'd3, 3'd0, 32'h10, 32'h0));
    send_item(make_item(FUNC_INSN, OP_ADDI, 3'd2, 3'd2, 32'h11, 32'h0));
    send_item(make_item(FUNC_INSN, OP_LOAD, 3'd4, 3'd2, 32'h20, 32'h0));
    send_item(make_item(FUNC_LDATA, OP_NOP, 3'd0, 3'd0, 32'h0, 32'hdead_beef));
    wait_drained();
    write_reg(CFG_THREAD_COUNT, 4'd0);
    send_item(make_item(FUNC_INSN, OP_NOP, 3'd0, 3'd0, 32'h0, 32'h0));
  endtask

  // Random streams over a series of settings; each phase ends with the
  // sender drained before the registers are rewritten.
  task automatic test_random_streams();
    bit         phase_mode  [10] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 0};
    logic [3:0] phase_count [10] = '{4, 4, 2, 3, 1, 15, 9, 0, 8, 4};
    int         target;
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      write_mode(phase_mode[p]);
      write_reg(CFG_THREAD_COUNT, phase_count[p]);
      target = executed_cnt + 180;
      while (executed_cnt < target) send_item(random_item());
    end
  endtask

  // Halt every thread, then poke the core: all_done must hold and all input
  // must be dropped, including with a smaller thread count.
  task automatic test_all_halted();
    wait_drained();
    write_mode(1'b1);
    write_reg(CFG_THREAD_COUNT, 4'd4);
    while (!every_thread_halted(THREADS)) begin
      if (shadow_pend)
        send_item(make_item(FUNC_LDATA, OP_NOP, 3'd0, 3'd0, 32'h0, $urandom));
      else
        send_item(make_item(FUNC_INSN, OP_HALT, 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)), $urandom, $urandom));
    end
    send_item(make_item(FUNC_INSN, OP_ADDI, 3'd1, 3'd1, 32'h1, 32'h0));
    send_item(make_item(FUNC_LDATA, OP_NOP, 3'd0, 3'd0, 32'h0, 32'h1234_5678));
    wait_drained();
    write_reg(CFG_THREAD_COUNT, 4'd2);
    send_item(make_item(FUNC_INSN, OP_HALT, 3'd0, 3'd0, 32'h0, 32'h0));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_shadow();
    executed_cnt = 0;
    mismatch_cnt = 0;
    burst_left   = 0;
    stall_style  = 0;
    stall_left   = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_thread_ops();
    test_thread_switching();
    test_random_streams();
    test_all_halted();

    wait_drained();
    repeat (4) @(posedge clk_i);  // catch any stray result after the last one
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run (~2000 transfers).
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
